/* design/ltfa_pkg.sv */
// shared types, register codes and constants for the led text frame assembler
// no dependencies; imported by every module of the block
`default_nettype none

package ltfa_pkg;

    // content bytes covered by the checksum
    localparam int CONTENT_BYTES = 60;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int WIN_W      = 14;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_KIND    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCAN_COUNT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IN_MODE       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_MODE      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STAY_MODE     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TEXT_COLOR    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_NUMBER = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_LABEL_COLORS  = 3'd7;

    localparam logic [WIN_W-1:0] WIN_MAX = 14'd9999;

    localparam logic [7:0] CHAR_OPEN  = 8'h28;
    localparam logic [7:0] CHAR_CLOSE = 8'h29;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;

    // k times the decimal weight of each digit place, thousands first
    localparam logic [WIN_W-1:0] DEC_MULT [4][10] = '{
        '{14'd0, 14'd1000, 14'd2000, 14'd3000, 14'd4000,
          14'd5000, 14'd6000, 14'd7000, 14'd8000, 14'd9000},
        '{14'd0, 14'd100, 14'd200, 14'd300, 14'd400,
          14'd500, 14'd600, 14'd700, 14'd800, 14'd900},
        '{14'd0, 14'd10, 14'd20, 14'd30, 14'd40,
          14'd50, 14'd60, 14'd70, 14'd80, 14'd90},
        '{14'd0, 14'd1, 14'd2, 14'd3, 14'd4,
          14'd5, 14'd6, 14'd7, 14'd8, 14'd9}
    };

    typedef struct packed {
        logic [7:0] text_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] content_byte;
        logic       is_trailer;
        logic [7:0] word_count;
        logic [7:0] frame_checksum;
        logic       overflow;
        logic       last_result;
    } t_out_item;

    typedef struct packed {
        logic [7:0]       frame_kind;
        logic [15:0]      scan_count;
        logic [7:0]       in_mode;
        logic [7:0]       out_mode;
        logic [7:0]       stay_mode;
        logic [2:0]       text_color;
        logic [WIN_W-1:0] window_number;
        logic [5:0]       label_colors;
    } t_cfg;

endpackage

`default_nettype wire

/* design/led_text_frame_assembler_top.sv */
// top level of the led text frame assembler: config registers, sequencer, output register
// depends on ltfa_pkg, ltfa_cfg_regs, ltfa_seq
`default_nettype none

// Text bytes go in one transfer each; content bytes come out one transfer per cycle
// from an output register while the receiver is ready. The first byte of a frame is
// preceded by an optional prefix: two transfers for each bracket and two for each
// decimal digit of the window number (up to twelve). Then an ASCII byte or the lead
// byte of a double-byte character gives two results, a trail byte one, and the byte
// marked last one more for the trailer. The rate is set by the single result path: one
// result item per cycle while the output is free, so an item holds the input until
// its last result is out. A new text byte is taken in the cycle its predecessor's
// last result moves to the output register, also when the result held there is leaving
// in that same cycle. Configuration is written through a plain write port and must
// only change while no frame byte is in flight; there is no clearing pass after reset.
module led_text_frame_assembler_top (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // configuration write port
    input  wire logic                             i_cfg_we,
    input  wire logic [ltfa_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [ltfa_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // text byte channel
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire ltfa_pkg::t_in_item               i_in_item,
    // content channel
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output ltfa_pkg::t_out_item                   o_out_item
);
    import ltfa_pkg::*;

    t_cfg      cfg;
    logic      out_free;
    logic      res_valid;
    t_out_item res;
    logic      r_out_valid;
    t_out_item r_out;

    ltfa_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // output slot can take a result when empty or being drained this cycle
    assign out_free = !r_out_valid || i_out_ready;

    ltfa_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_item      (i_in_item),
        .i_out_free  (out_free),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // output register, control part
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= res_valid;
        end
    end

    // output register, payload part
    always_ff @(posedge i_clk) begin
        if (out_free && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

`default_nettype wire

/* design/ltfa_cfg_regs.sv */
// configuration register file of the led text frame assembler
// depends on ltfa_pkg
`default_nettype none

module ltfa_cfg_regs (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [ltfa_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [ltfa_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output ltfa_pkg::t_cfg                         o_cfg
);
    import ltfa_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            // all registers zero except the text color
            r_cfg <= '{text_color: 3'd1, default: '0};
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_FRAME_KIND:    r_cfg.frame_kind    <= i_cfg_data[7:0];
                REG_SCAN_COUNT:    r_cfg.scan_count    <= i_cfg_data[15:0];
                REG_IN_MODE:       r_cfg.in_mode       <= i_cfg_data[7:0];
                REG_OUT_MODE:      r_cfg.out_mode      <= i_cfg_data[7:0];
                REG_STAY_MODE:     r_cfg.stay_mode     <= i_cfg_data[7:0];
                REG_TEXT_COLOR:    r_cfg.text_color    <= i_cfg_data[2:0];
                REG_WINDOW_NUMBER: r_cfg.window_number <= i_cfg_data[WIN_W-1:0];
                REG_LABEL_COLORS:  r_cfg.label_colors  <= i_cfg_data[5:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

/* design/ltfa_digit.sv */
// one decimal digit step: digit at a place and the remainder below it
// depends on ltfa_pkg (weight table)
`default_nettype none

module ltfa_digit (
    input  wire logic [ltfa_pkg::WIN_W-1:0] i_rem,
    input  wire logic [1:0]                 i_idx,
    output logic [3:0]                      o_digit,
    output logic [ltfa_pkg::WIN_W-1:0]      o_rem_next
);
    import ltfa_pkg::*;

    // parallel compares against the nine multiples of the place weight
    always_comb begin
        o_digit = 4'd0;
        for (int k = 1; k < 10; k++) begin
            if (i_rem >= DEC_MULT[i_idx][k]) begin
                o_digit = 4'(k);
            end
        end
        o_rem_next = i_rem - DEC_MULT[i_idx][o_digit];
    end

endmodule

`default_nettype wire

/* design/ltfa_seq.sv */
// item register, result sequencer and frame state of the assembler
// depends on ltfa_pkg and ltfa_digit
`default_nettype none

module ltfa_seq (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire ltfa_pkg::t_cfg    i_cfg,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire ltfa_pkg::t_in_item i_item,
    input  wire logic              i_out_free,
    output logic                   o_res_valid,
    output ltfa_pkg::t_out_item    o_res
);
    import ltfa_pkg::*;

    localparam logic [2:0] PH_OPEN    = 3'd0;
    localparam logic [2:0] PH_DIGIT   = 3'd1;
    localparam logic [2:0] PH_CLOSE   = 3'd2;
    localparam logic [2:0] PH_BODY    = 3'd3;
    localparam logic [2:0] PH_TRAILER = 3'd4;

    localparam logic [6:0] POS_MAX = 7'd127;
    localparam logic [6:0] AREA    = 7'(CONTENT_BYTES);

    // item register and sequencing
    logic             r_in_valid;
    t_in_item         r_item;
    logic             r_fresh;
    logic [2:0]       r_phase;
    logic             r_sub;
    logic [WIN_W-1:0] r_rem;
    logic [1:0]       r_idx;

    // frame state
    logic [6:0] r_pos;
    logic [7:0] r_cnt;
    logic [7:0] r_sum;
    logic       r_await;
    logic       r_pdone;

    logic [2:0]       bracket, dcol;
    logic [WIN_W-1:0] wcl;
    logic [1:0]       start_idx;
    logic [2:0]       init_phase;
    logic [2:0]       cur_phase;
    logic             cur_sub;
    logic [WIN_W-1:0] cur_rem;
    logic [1:0]       cur_idx;
    logic [3:0]       digit;
    logic [WIN_W-1:0] rem_next;

    logic [2:0]       n_phase;
    logic             n_sub;
    logic [WIN_W-1:0] n_rem;
    logic [1:0]       n_idx;
    logic             done;
    logic             is_body;
    logic             cnt_inc;
    logic             n_await;
    logic [7:0]       byte_out;
    logic             emit;

    assign bracket = i_cfg.label_colors[5:3];
    assign dcol    = i_cfg.label_colors[2:0];
    assign wcl     = (i_cfg.window_number > WIN_MAX) ? WIN_MAX : i_cfg.window_number;

    always_comb begin
        priority if (wcl >= 14'd1000) start_idx = 2'd0;
        else if (wcl >= 14'd100)      start_idx = 2'd1;
        else if (wcl >= 14'd10)       start_idx = 2'd2;
        else                          start_idx = 2'd3;
    end

    always_comb begin
        priority if (r_pdone)      init_phase = PH_BODY;
        else if (bracket != 3'd0)  init_phase = PH_OPEN;
        else if (wcl != '0)        init_phase = PH_DIGIT;
        else                       init_phase = PH_BODY;
    end

    assign cur_phase = r_fresh ? init_phase : r_phase;
    assign cur_sub   = r_fresh ? 1'b0 : r_sub;
    assign cur_rem   = r_fresh ? wcl : r_rem;
    assign cur_idx   = r_fresh ? start_idx : r_idx;

    ltfa_digit u_digit (
        .i_rem      (cur_rem),
        .i_idx      (cur_idx),
        .o_digit    (digit),
        .o_rem_next (rem_next)
    );

    always_comb begin
        n_phase  = cur_phase;
        n_sub    = cur_sub;
        n_rem    = cur_rem;
        n_idx    = cur_idx;
        done     = 1'b0;
        is_body  = 1'b0;
        cnt_inc  = 1'b0;
        n_await  = r_await;
        byte_out = 8'd0;
        unique case (cur_phase)
            PH_OPEN: begin
                if (!cur_sub) begin
                    byte_out = {bracket, 5'd1};
                    n_sub    = 1'b1;
                end else begin
                    byte_out = CHAR_OPEN;
                    n_sub    = 1'b0;
                    n_phase  = (wcl != '0) ? PH_DIGIT : PH_CLOSE;
                end
            end
            PH_DIGIT: begin
                if (!cur_sub) begin
                    byte_out = {dcol, 5'd1};
                    n_sub    = 1'b1;
                end else begin
                    byte_out = CHAR_ZERO + {4'd0, digit};
                    n_sub    = 1'b0;
                    n_rem    = rem_next;
                    if (cur_idx == 2'd3) begin
                        n_phase = (bracket != 3'd0) ? PH_CLOSE : PH_BODY;
                    end else begin
                        n_idx = cur_idx + 2'd1;
                    end
                end
            end
            PH_CLOSE: begin
                if (!cur_sub) begin
                    byte_out = {bracket, 5'd1};
                    n_sub    = 1'b1;
                end else begin
                    byte_out = CHAR_CLOSE;
                    n_sub    = 1'b0;
                    n_phase  = PH_BODY;
                end
            end
            PH_BODY: begin
                is_body = 1'b1;
                if (r_await) begin
                    // trail byte of a double-byte character
                    byte_out = r_item.text_byte;
                    n_await  = 1'b0;
                end else if (!cur_sub) begin
                    byte_out = r_item.text_byte[7] ? {i_cfg.text_color, 5'd0}
                                                   : {i_cfg.text_color, 5'd1};
                    n_sub    = 1'b1;
                end else begin
                    byte_out = r_item.text_byte;
                    n_sub    = 1'b0;
                    cnt_inc  = 1'b1;
                    n_await  = r_item.text_byte[7];
                end
                if (r_await || cur_sub) begin
                    if (r_item.last_byte) begin
                        n_phase = PH_TRAILER;
                    end else begin
                        done = 1'b1;
                    end
                end
            end
            PH_TRAILER: begin
                done = 1'b1;
            end
            default: begin
                done = 1'b1;
            end
        endcase
    end

    always_comb begin
        o_res = '0;
        o_res.last_result = done;
        if (cur_phase == PH_TRAILER) begin
            o_res.is_trailer     = 1'b1;
            o_res.word_count     = r_cnt;
            o_res.frame_checksum = r_sum + i_cfg.frame_kind + i_cfg.scan_count[7:0]
                                 + i_cfg.scan_count[15:8] + i_cfg.in_mode
                                 + i_cfg.out_mode + i_cfg.stay_mode + r_cnt;
            o_res.overflow       = (r_pos > AREA);
        end else begin
            o_res.content_byte = byte_out;
            o_res.overflow     = (r_pos >= AREA);
        end
    end

    assign o_res_valid = r_in_valid;
    assign emit        = r_in_valid && i_out_free;
    assign o_in_ready  = !r_in_valid || (i_out_free && done);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_fresh    <= 1'b1;
            r_pos      <= '0;
            r_cnt      <= '0;
            r_sum      <= '0;
            r_await    <= 1'b0;
            r_pdone    <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                r_in_valid <= 1'b1;
            end else if (emit && done) begin
                r_in_valid <= 1'b0;
            end
            if (emit) begin
                r_fresh <= done;
                if (cur_phase == PH_TRAILER) begin
                    r_pos   <= '0;
                    r_cnt   <= '0;
                    r_sum   <= '0;
                    r_await <= 1'b0;
                    r_pdone <= 1'b0;
                end else begin
                    if (r_pos < AREA) begin
                        r_sum <= r_sum + byte_out;
                    end
                    if (r_pos < POS_MAX) begin
                        r_pos <= r_pos + 7'd1;
                    end
                    if (cnt_inc) begin
                        r_cnt <= r_cnt + 8'd1;
                    end
                    r_await <= n_await;
                    if (is_body) begin
                        r_pdone <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_item <= i_item;
        end
        if (emit) begin
            r_phase <= n_phase;
            r_sub   <= n_sub;
            r_rem   <= n_rem;
            r_idx   <= n_idx;
        end
    end

    // a pending trail byte only exists once the prefix is out
    a_await_after_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_await |-> r_pdone)
        else $error("trail byte pending before prefix done");

    // prefix flag drops only through a trailer
    a_pdone_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(r_pdone) && $past(i_rst_n)) |-> $past(emit && o_res.is_trailer))
        else $error("prefix flag cleared without trailer");

    // digit remainder stays a four-digit value
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_fresh && r_phase == PH_DIGIT) |-> (r_rem <= WIN_MAX))
        else $error("digit remainder out of range");

    // trailer returns the frame state to zero
    a_trailer_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && o_res.is_trailer) |=> (r_pos == '0 && r_cnt == '0 && !r_await))
        else $error("frame state not cleared after trailer");

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
// self-checking testbench for led_text_frame_assembler_top: random frames, register settings
// and handshake stalls, checked against an in-bench prediction of every content transfer
// depends on ltfa_pkg and the led_text_frame_assembler_top rtl
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ltfa_pkg::*;

    // generous bound: 15 results per byte at worst, long stalls
    localparam int CYCLE_LIMIT = 500000;
    // receiver hold-off long enough to back the block up into its text input
    localparam int LONG_HOLD   = 400;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    t_in_item              in_item   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_out_item             out_item;

    led_text_frame_assembler_top u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // text bytes waiting for the driver, content items waiting for the monitor
    t_in_item  pending_text[$];
    t_out_item expected_content[$];

    // shadow of the register file as last programmed
    t_cfg regs = '{text_color: 3'd1, default: '0};

    // frame state mirrored from the block
    logic [6:0] content_pos = '0;   // saturates at 127
    logic [7:0] words       = '0;   // character count, wraps
    logic [7:0] area_sum    = '0;   // sum of content bytes inside the checksum area
    bit         trail_due   = 1'b0; // next text byte is the trail of a double-byte char
    bit         label_sent  = 1'b0; // window label already sent for this frame

    // bookkeeping
    int queued      = 0;
    int accepted    = 0;
    int checked     = 0;
    int mismatches  = 0;
    int frames      = 0;
    int settings    = 0;
    int cycles      = 0;
    int send_gap    = 0;
    int stall_left  = 0;
    int hold_left   = 0;
    bit idling      = 1'b1;
    bit hold_request = 1'b0;
    bit hold_done   = 1'b0;

    // ---------------------------------------------------------------------
    // prediction
    // ---------------------------------------------------------------------

    // one content byte: flagged past the area, summed only inside it
    function automatic void emit_byte(logic [7:0] value);
        t_out_item item;
        item = '0;
        item.content_byte = value;
        item.overflow = (content_pos >= CONTENT_BYTES);
        if (content_pos < CONTENT_BYTES)
            area_sum = area_sum + value;
        if (content_pos != 7'd127)
            content_pos = content_pos + 7'd1;
        expected_content.push_back(item);
    endfunction

    // attribute 32*color+1 followed by the character
    function automatic void emit_pair(logic [2:0] color, logic [7:0] value);
        emit_byte({color, 5'd1});
        emit_byte(value);
    endfunction

    // optional "(digits)" label ahead of the first character of a frame
    function automatic void emit_label();
        logic [2:0] bracket_color;
        logic [2:0] digit_color;
        int         win;
        int         place;
        bit         started;
        bracket_color = regs.label_colors[5:3];
        digit_color   = regs.label_colors[2:0];
        // window numbers above the four-digit range clamp to the largest one
        win = (regs.window_number > WIN_MAX) ? int'(WIN_MAX) : int'(regs.window_number);
        started = 1'b0;
        if (bracket_color != 3'd0)
            emit_pair(bracket_color, CHAR_OPEN);
        if (win != 0) begin
            // leading zeros dropped, inner zeros kept
            for (place = 1000; place != 0; place = place / 10) begin
                if ((win / place) % 10 != 0 || started || place == 1) begin
                    started = 1'b1;
                    emit_pair(digit_color, CHAR_ZERO + 8'((win / place) % 10));
                end
            end
        end
        if (bracket_color != 3'd0)
            emit_pair(bracket_color, CHAR_CLOSE);
    endfunction

    // all content items one accepted text byte causes, last one marked
    function automatic void assemble_expected(t_in_item item);
        t_out_item tail;
        if (!label_sent) begin
            emit_label();
            label_sent = 1'b1;
        end
        if (trail_due) begin
            // trail byte goes out as is and is not a new character
            emit_byte(item.text_byte);
            trail_due = 1'b0;
        end else if (item.text_byte[7]) begin
            // lead byte of a double-byte character: plain color attribute, no +1
            emit_byte({regs.text_color, 5'd0});
            emit_byte(item.text_byte);
            words = words + 8'd1;
            trail_due = 1'b1;
        end else begin
            emit_pair(regs.text_color, item.text_byte);
            words = words + 8'd1;
        end
        if (item.last_byte) begin
            // trailer, even when a lead byte still waits for its trail
            tail = '0;
            tail.is_trailer = 1'b1;
            tail.word_count = words;
            tail.frame_checksum = area_sum + regs.frame_kind + regs.scan_count[7:0]
                                + regs.scan_count[15:8] + regs.in_mode + regs.out_mode
                                + regs.stay_mode + words;
            tail.overflow = (content_pos > CONTENT_BYTES);
            expected_content.push_back(tail);
            content_pos = '0;
            words       = '0;
            area_sum    = '0;
            trail_due   = 1'b0;
            label_sent  = 1'b0;
        end
        tail = expected_content.pop_back();
        tail.last_result = 1'b1;
        expected_content.push_back(tail);
    endfunction

    // ---------------------------------------------------------------------
    // checking
    // ---------------------------------------------------------------------

    function automatic void compare_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // ---------------------------------------------------------------------
    // text driver: feeds pending_text, predicts on every accepted transfer
    // ---------------------------------------------------------------------
    always @(posedge clk) begin : text_driver
        if (rst_n) begin
            if (in_valid && in_ready) begin
                assemble_expected(in_item);
                accepted++;
            end
            // free to change the payload only when nothing is on offer or it just went
            if (!in_valid || in_ready) begin
                if (send_gap != 0) begin
                    send_gap--;
                    in_valid <= 1'b0;
                end else if (idling && $urandom_range(0, 7) == 0) begin
                    // burst of idle cycles, this one included
                    send_gap = $urandom_range(0, 9);
                    in_valid <= 1'b0;
                end else if (pending_text.size() != 0) begin
                    in_item  <= pending_text.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // content monitor: checks transfers, stalls the receiver side
    // ---------------------------------------------------------------------
    always @(posedge clk) begin : content_monitor
        t_out_item want;
        if (rst_n && out_valid && out_ready) begin
            checked++;
            if (expected_content.size() == 0) begin
                $display("%0t ns: content transfer with nothing expected, expected none, actual %0h",
                         $time, out_item);
                mismatches++;
            end else begin
                want = expected_content.pop_front();
                compare_field("content_byte", want.content_byte, out_item.content_byte);
                compare_field("is_trailer", 8'(want.is_trailer), 8'(out_item.is_trailer));
                compare_field("word_count", want.word_count, out_item.word_count);
                compare_field("frame_checksum", want.frame_checksum, out_item.frame_checksum);
                compare_field("overflow", 8'(want.overflow), 8'(out_item.overflow));
                compare_field("last_result", 8'(want.last_result), 8'(out_item.last_result));
            end
        end
        // receiver pacing: one long hold-off on request, else short random stalls
        if (hold_left != 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else if (hold_request && !hold_done) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD - 1;
            out_ready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left--;
            out_ready <= 1'b0;
        end else if (idling && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 9);
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    // watchdog
    always @(posedge clk) begin : watchdog
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("%0t ns: no progress, %0d transfers still expected", $time,
                     expected_content.size());
            $display("led_text_frame_assembler_top regression: fail");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------------

    task automatic add_text(logic [7:0] value, bit last);
        t_in_item item;
        item.text_byte = value;
        item.last_byte = last;
        pending_text.push_back(item);
        queued++;
        if (last)
            frames++;
    endtask

    // frame of random text, mostly ascii with some double-byte leads, or ascii only on request
    task automatic add_frame(int len, bit ascii_only);
        logic [7:0] value;
        for (int k = 0; k < len; k++) begin
            if (ascii_only || $urandom_range(0, 9) < 7)
                value = 8'($urandom_range(0, 127));
            else
                value = 8'($urandom_range(128, 255));
            add_text(value, k == len - 1);
        end
    endtask

    // wait until every byte went in and every content transfer came out,
    // then give the output register time to drain
    task automatic settle();
        while (accepted != queued || expected_content.size() != 0)
            @(negedge clk);
        repeat (8) @(posedge clk);
    endtask

    // write every register, with junk above each field narrower than the port
    task automatic program_regs(t_cfg setting);
        logic [CFG_IDX_W-1:0] idx;
        for (int k = 0; k < 8; k++) begin
            idx = k[CFG_IDX_W-1:0];
            @(posedge clk);
            cfg_we    <= 1'b1;
            cfg_index <= idx;
            case (idx)
                REG_FRAME_KIND:    cfg_data <= {8'($urandom), setting.frame_kind};
                REG_SCAN_COUNT:    cfg_data <= setting.scan_count;
                REG_IN_MODE:       cfg_data <= {8'($urandom), setting.in_mode};
                REG_OUT_MODE:      cfg_data <= {8'($urandom), setting.out_mode};
                REG_STAY_MODE:     cfg_data <= {8'($urandom), setting.stay_mode};
                REG_TEXT_COLOR:    cfg_data <= {13'($urandom), setting.text_color};
                REG_WINDOW_NUMBER: cfg_data <= {2'($urandom), setting.window_number};
                REG_LABEL_COLORS:  cfg_data <= {10'($urandom), setting.label_colors};
                default:           cfg_data <= '0;
            endcase
        end
        @(posedge clk);
        cfg_we <= 1'b0;
        regs = setting;
        settings++;
    endtask

    initial begin : stimulus
        t_cfg setting;
        int   phase_items;
        int   len;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // reset values: color 1, no label, zero header
        add_text(8'h00, 1'b1);
        // ascii, a full double-byte char, then a lead byte that ends the frame
        add_text(8'h7F, 1'b0);
        add_text(8'h80, 1'b0);
        add_text(8'hFF, 1'b0);
        add_text(8'hC3, 1'b1);
        // trail byte below 128 closing the frame
        add_text(8'hFF, 1'b0);
        add_text(8'h00, 1'b1);
        add_text(8'h41, 1'b0);
        add_text(8'hAA, 1'b0);
        add_text(8'h55, 1'b1);
        settle();

        // everything at its top: full label with the window clamped to 9999
        setting = '{frame_kind: 8'hFF, scan_count: 16'hFFFF, in_mode: 8'hFF,
                    out_mode: 8'hFF, stay_mode: 8'hFF, text_color: 3'd7,
                    window_number: 14'h3FFF, label_colors: 6'h3F};
        program_regs(setting);
        add_text(8'h7A, 1'b1);
        add_text(8'h80, 1'b0);
        add_text(8'h7F, 1'b1);
        settle();

        // color 0 text, digits only with an inner zero
        setting = '0;
        setting.window_number = 14'd1005;
        setting.label_colors  = 6'b000101;
        program_regs(setting);
        add_text(8'h20, 1'b0);
        add_text(8'hFE, 1'b0);
        add_text(8'h01, 1'b1);
        settle();

        // brackets around nothing, window 9999 exactly in the next phase
        setting.window_number = 14'd0;
        setting.label_colors  = 6'b010000;
        program_regs(setting);
        add_text(8'h55, 1'b1);
        settle();
        setting.window_number = 14'd9999;
        setting.label_colors  = 6'b001010;
        program_regs(setting);
        add_text(8'h31, 1'b1);
        settle();

        // random settings and frames; the last phase runs without idling
        for (int phase = 0; phase < 6; phase++) begin
            setting.frame_kind = 8'($urandom);
            setting.scan_count = 16'($urandom);
            setting.in_mode    = 8'($urandom);
            setting.out_mode   = 8'($urandom);
            setting.stay_mode  = 8'($urandom);
            setting.text_color = 3'($urandom);
            case ($urandom_range(0, 3))
                0:       setting.window_number = 14'd0;
                1:       setting.window_number = 14'($urandom_range(1, 9));
                2:       setting.window_number = 14'($urandom_range(10, 9999));
                default: setting.window_number = 14'($urandom_range(10000, 16383));
            endcase
            setting.label_colors = 6'($urandom);
            program_regs(setting);
            idling = (phase != 5) && ($urandom_range(0, 3) != 0);

            if (phase == 2) begin
                // receiver goes quiet while a long frame keeps coming
                hold_request = 1'b1;
                add_frame(40, 1'b0);
            end
            if (phase == 3)
                // content position runs far past the area and saturates
                add_frame(70, 1'b1);

            phase_items = 0;
            while (phase_items < 10) begin
                len = ($urandom_range(0, 5) == 0) ? $urandom_range(25, 45)
                                                  : $urandom_range(1, 10);
                add_frame(len, 1'b0);
                phase_items += len;
            end
            settle();
        end

        repeat (20) @(posedge clk);
        $display("covered %0d frames of %0d text bytes under %0d register settings",
                 frames, accepted, settings);
        $display("%0d content transfers checked, %0d mismatches", checked, mismatches);
        if (mismatches == 0 && expected_content.size() == 0) begin
            $display("led_text_frame_assembler_top regression: pass");
        end else begin
            $display("led_text_frame_assembler_top regression: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* filelist.f */
design/ltfa_pkg.sv
design/ltfa_cfg_regs.sv
design/ltfa_digit.sv
design/ltfa_seq.sv
design/led_text_frame_assembler_top.sv
tb/sv/tb_top.sv
